/* design/kil_pkg.sv */
// shared types and constants of the keyword/identifier/integer lexer
package kil_pkg;

  // default word buffer depth
  localparam int unsigned MaxWordDef = 16;
  localparam int unsigned LenW       = 7;
  localparam int unsigned AddrW      = 6;

  localparam logic [30:0] ValueMax = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    KwBegin  = 5'd0,
    KwEnd    = 5'd1,
    KwIf     = 5'd2,
    KwThen   = 5'd3,
    KwElse   = 5'd4,
    KIdent   = 5'd5,
    KInt     = 5'd6,
    KPlus    = 5'd7,
    KMinus   = 5'd8,
    KStar    = 5'd9,
    KSlash   = 5'd10,
    KLParen  = 5'd11,
    KRParen  = 5'd12,
    KComma   = 5'd13,
    KSemi    = 5'd14,
    KColon   = 5'd15,
    KAssign  = 5'd16,
    KEqual   = 5'd17,
    KIllegal = 5'd18
  } kind_e;

  // write port of the word buffer
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  // one command: optional flushed token or word run, then optional single token
  typedef struct packed {
    logic            has_a;
    logic            a_word;
    kind_e           a_kind;
    logic [30:0]     a_value;
    logic            a_ovf;
    logic [LenW-1:0] a_len;
    logic            has_b;
    kind_e           b_kind;
  } cmd_t;

endpackage

/* design/kil_stream_if.sv */
// stream interfaces for characters in and tokens out
interface kil_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface kil_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [7:0]  id_char;
  logic [30:0] value;
  logic        overflow;
  logic        last;

  modport source (output valid, kind, id_char, value, overflow, last, input ready);
  modport sink (input valid, kind, id_char, value, overflow, last, output ready);
endinterface

/* design/kil_front.sv */
// scanner front: accepts characters, tracks scan mode, queues token commands
module kil_front #(
  parameter int unsigned MaxWord = kil_pkg::MaxWordDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  kil_in_if.sink              in_i,
  input  logic                full_i,
  input  logic                word_done_i,
  output logic                push_o,
  output kil_pkg::cmd_t       cmd_o,
  output kil_pkg::buf_wr_t    wr_o
);

  localparam int unsigned LW = $clog2(MaxWord + 1);
  localparam int unsigned IW = $clog2(MaxWord);

  localparam logic [2:0] MIdle    = 3'd0;
  localparam logic [2:0] MWord    = 3'd1;
  localparam logic [2:0] MNumber  = 3'd2;
  localparam logic [2:0] MColon   = 3'd3;
  localparam logic [2:0] MSlash   = 3'd4;
  localparam logic [2:0] MComment = 3'd5;
  localparam logic [2:0] MStar    = 3'd6;

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChEqual  = 8'h3D;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDel    = 8'h7F;

  logic [2:0]    mode_q, mode_d;
  logic [LW-1:0] len_q, len_d;
  logic [30:0]   acc_q, acc_d;
  logic          ovf_q, ovf_d;
  logic          busy_q, busy_d;
  logic [7:0]    pfx_q [5];

  logic             accept;
  logic [7:0]       c;
  logic             is_alpha, is_digit, is_blank;
  logic [34:0]      acc_sum;
  logic             kw_hit;
  kil_pkg::kind_e   kw_kind;
  kil_pkg::cmd_t    cmd;
  kil_pkg::buf_wr_t wr;
  logic             pfx_we;
  logic [2:0]       pfx_idx;

  assign c        = in_i.ch;
  assign accept   = in_i.valid && in_i.ready;
  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  // control bytes, space and delete
  assign is_blank = (c <= ChSpace) || (c == ChDel);

  // ten times the accumulator plus the new digit
  assign acc_sum = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {31'b0, c[3:0]};

  always_comb begin
    kw_hit  = 1'b1;
    kw_kind = kil_pkg::KwBegin;
    priority if (len_q == LW'(5) &&
                 {pfx_q[0], pfx_q[1], pfx_q[2], pfx_q[3], pfx_q[4]} == "begin") begin
      kw_kind = kil_pkg::KwBegin;
    end else if (len_q == LW'(3) && {pfx_q[0], pfx_q[1], pfx_q[2]} == "end") begin
      kw_kind = kil_pkg::KwEnd;
    end else if (len_q == LW'(2) && {pfx_q[0], pfx_q[1]} == "if") begin
      kw_kind = kil_pkg::KwIf;
    end else if (len_q == LW'(4) &&
                 {pfx_q[0], pfx_q[1], pfx_q[2], pfx_q[3]} == "then") begin
      kw_kind = kil_pkg::KwThen;
    end else if (len_q == LW'(4) &&
                 {pfx_q[0], pfx_q[1], pfx_q[2], pfx_q[3]} == "else") begin
      kw_kind = kil_pkg::KwElse;
    end else begin
      kw_hit = 1'b0;
    end
  end

  always_comb begin
    logic flush_w;
    logic flush_n;
    logic start;
    flush_w = 1'b0;
    flush_n = 1'b0;
    start   = 1'b0;
    mode_d  = mode_q;
    len_d   = len_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    cmd     = '0;
    wr      = '0;
    pfx_we  = 1'b0;
    pfx_idx = len_q[2:0];

    if (in_i.end_of_input) begin
      unique case (mode_q)
        MWord:   flush_w = 1'b1;
        MNumber: flush_n = 1'b1;
        MColon: begin
          cmd.has_a  = 1'b1;
          cmd.a_kind = kil_pkg::KColon;
        end
        MSlash: begin
          cmd.has_a  = 1'b1;
          cmd.a_kind = kil_pkg::KSlash;
        end
        default: ;
      endcase
      mode_d = MIdle;
    end else begin
      unique case (mode_q)
        MWord: begin
          if (is_alpha || is_digit) begin
            if (len_q < LW'(MaxWord)) begin
              wr.en   = 1'b1;
              wr.addr = kil_pkg::AddrW'(len_q[IW-1:0]);
              wr.data = c;
              len_d   = len_q + LW'(1);
              pfx_we  = (len_q < LW'(5));
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            flush_w = 1'b1;
            start   = 1'b1;
          end
        end
        MNumber: begin
          if (is_digit) begin
            if (acc_sum > {4'b0, kil_pkg::ValueMax}) begin
              acc_d = kil_pkg::ValueMax;
              ovf_d = 1'b1;
            end else begin
              acc_d = acc_sum[30:0];
            end
          end else begin
            flush_n = 1'b1;
            start   = 1'b1;
          end
        end
        MColon: begin
          cmd.has_a = 1'b1;
          if (c == ChEqual) begin
            cmd.a_kind = kil_pkg::KAssign;
            mode_d     = MIdle;
          end else begin
            cmd.a_kind = kil_pkg::KColon;
            start      = 1'b1;
          end
        end
        MSlash: begin
          if (c == ChStar) begin
            mode_d = MComment;
          end else begin
            cmd.has_a  = 1'b1;
            cmd.a_kind = kil_pkg::KSlash;
            start      = 1'b1;
          end
        end
        MComment: begin
          if (c == ChStar) mode_d = MStar;
        end
        MStar: begin
          if (c == ChSlash) mode_d = MIdle;
          else if (c != ChStar) mode_d = MComment;
        end
        default: start = 1'b1;
      endcase
    end

    // pending word: keyword token or identifier run
    if (flush_w) begin
      cmd.has_a = 1'b1;
      if (!ovf_q && kw_hit) begin
        cmd.a_kind = kw_kind;
      end else begin
        cmd.a_word = 1'b1;
        cmd.a_kind = kil_pkg::KIdent;
        cmd.a_ovf  = ovf_q;
        cmd.a_len  = kil_pkg::LenW'(len_q);
      end
      len_d = '0;
      ovf_d = 1'b0;
    end

    if (flush_n) begin
      cmd.has_a   = 1'b1;
      cmd.a_kind  = kil_pkg::KInt;
      cmd.a_value = acc_q;
      cmd.a_ovf   = ovf_q;
      acc_d       = '0;
      ovf_d       = 1'b0;
    end

    // terminating character starts its own token in the same step
    if (start) begin
      mode_d = MIdle;
      priority if (is_blank) begin
        mode_d = MIdle;
      end else if (is_alpha) begin
        wr.en   = 1'b1;
        wr.addr = '0;
        wr.data = c;
        len_d   = LW'(1);
        ovf_d   = 1'b0;
        pfx_we  = 1'b1;
        pfx_idx = 3'd0;
        mode_d  = MWord;
      end else if (is_digit) begin
        acc_d  = {27'b0, c[3:0]};
        ovf_d  = 1'b0;
        mode_d = MNumber;
      end else begin
        unique case (c)
          ChColon: mode_d = MColon;
          ChSlash: mode_d = MSlash;
          ChPlus: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KPlus;
          end
          ChMinus: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KMinus;
          end
          ChStar: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KStar;
          end
          ChLParen: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KLParen;
          end
          ChRParen: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KRParen;
          end
          ChComma: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KComma;
          end
          ChSemi: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KSemi;
          end
          ChEqual: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KEqual;
          end
          default: begin
            cmd.has_b  = 1'b1;
            cmd.b_kind = kil_pkg::KIllegal;
          end
        endcase
      end
    end
  end

  assign in_i.ready = !busy_q && !full_i;
  assign push_o     = accept && (cmd.has_a || cmd.has_b);
  assign cmd_o      = cmd;
  assign wr_o       = accept ? wr : '0;

  // buffer stays busy until the back end has read out the whole run
  always_comb begin
    busy_d = busy_q;
    if (accept && cmd.has_a && cmd.a_word) busy_d = 1'b1;
    else if (word_done_i) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
      len_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        acc_q  <= acc_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pfx_we) pfx_q[pfx_idx] <= c;
  end

endmodule

/* design/kil_cmd_fifo.sv */
// two-entry command queue between scanner front and token back end
module kil_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kil_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output kil_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  kil_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

/* design/kil_back.sv */
// token back end: word buffer memory, command sequencer, output register
module kil_back #(
  parameter int unsigned MaxWord = kil_pkg::MaxWordDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kil_pkg::buf_wr_t wr_i,
  input  kil_pkg::cmd_t    cmd_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             word_done_o,
  kil_out_if.source        out_o
);

  localparam int unsigned LW = $clog2(MaxWord + 1);
  localparam int unsigned IW = $clog2(MaxWord);

  localparam logic [2:0] BIdle = 3'd0;
  localparam logic [2:0] BRead = 3'd1;
  localparam logic [2:0] BWord = 3'd2;
  localparam logic [2:0] BTokA = 3'd3;
  localparam logic [2:0] BTokB = 3'd4;

  logic [7:0]    mem_q [MaxWord];
  logic [7:0]    rd_q;
  logic [2:0]    st_q, st_d;
  kil_pkg::cmd_t work_q, work_d;
  logic [IW-1:0] idx_q, idx_d;

  logic           out_valid_q;
  kil_pkg::kind_e kind_q, kind_d;
  logic [7:0]     id_q, id_d;
  logic [30:0]    val_q, val_d;
  logic           ovf_q, ovf_d;
  logic           last_q, last_d;

  logic free, load, rd_en, run_end;

  assign free    = !out_valid_q || out_o.ready;
  assign run_end = (LW'(idx_q) + LW'(1)) == work_q.a_len[LW-1:0];

  always_comb begin
    st_d        = st_q;
    work_d      = work_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    load        = 1'b0;
    word_done_o = 1'b0;
    kind_d      = work_q.b_kind;
    id_d        = '0;
    val_d       = '0;
    ovf_d       = 1'b0;
    last_d      = 1'b1;

    unique case (st_q)
      BIdle: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          work_d = cmd_i;
          idx_d  = '0;
          if (!cmd_i.has_a) st_d = BTokB;
          else if (cmd_i.a_word) st_d = BRead;
          else st_d = BTokA;
        end
      end
      BRead: begin
        rd_en = 1'b1;
        st_d  = BWord;
      end
      BWord: begin
        if (free) begin
          load   = 1'b1;
          kind_d = kil_pkg::KIdent;
          id_d   = rd_q;
          ovf_d  = work_q.a_ovf;
          last_d = run_end;
          if (run_end) begin
            word_done_o = 1'b1;
            st_d        = work_q.has_b ? BTokB : BIdle;
          end else begin
            idx_d = idx_q + IW'(1);
            st_d  = BRead;
          end
        end
      end
      BTokA: begin
        if (free) begin
          load   = 1'b1;
          kind_d = work_q.a_kind;
          val_d  = work_q.a_value;
          ovf_d  = work_q.a_ovf;
          st_d   = work_q.has_b ? BTokB : BIdle;
        end
      end
      BTokB: begin
        if (free) begin
          load = 1'b1;
          st_d = BIdle;
        end
      end
      default: st_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr[IW-1:0]] <= wr_i.data;
    if (rd_en) rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BIdle;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    idx_q  <= idx_d;
    if (load) begin
      kind_q <= kind_d;
      id_q   <= id_d;
      val_q  <= val_d;
      ovf_q  <= ovf_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = kind_q;
  assign out_o.id_char  = id_q;
  assign out_o.value    = val_q;
  assign out_o.overflow = ovf_q;
  assign out_o.last     = last_q;

endmodule

/* design/keyword_identifier_integer_lexer_unit.sv */
// top level of the keyword/identifier/integer lexer
//
//  channel | dir | beat                                   | accepted when
//  in_i    | in  | ch, end_of_input                       | valid & ready
//  out_o   | out | kind, id_char, value, overflow, last   | valid & ready
//
// the front takes one character a cycle while the command queue has room and
// the word buffer is not held by an identifier run still being read out
// the back end pops a command, gives each token through the output register and
// each identifier character through a buffer memory read, then the output register
// reset clears the scan state, the queue and the output valid flag; the word
// buffer is not cleared and needs no clearing pass
// a stalled output holds its beat while the front keeps scanning into the queue
module keyword_identifier_integer_lexer_unit #(
  parameter int unsigned MaxWord = kil_pkg::MaxWordDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kil_in_if.sink    in_i,
  kil_out_if.source out_o
);

  // front to queue
  kil_pkg::cmd_t    push_cmd;
  logic             push;
  logic             q_full;
  // queue to back end
  kil_pkg::cmd_t    pop_cmd;
  logic             pop;
  logic             q_empty;
  // word buffer writes and release
  kil_pkg::buf_wr_t buf_wr;
  logic             word_done;

  kil_front #(
    .MaxWord(MaxWord)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .full_i     (q_full),
    .word_done_i(word_done),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .wr_o       (buf_wr)
  );

  kil_cmd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  kil_back #(
    .MaxWord(MaxWord)
  ) u_back (
    .clk_i,
    .rst_ni,
    .wr_i       (buf_wr),
    .cmd_i      (pop_cmd),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .word_done_o(word_done),
    .out_o
  );

endmodule

/* design/kil_checker.sv */
// port-level checks of the lexer, bound to the top level
module kil_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  kind_i,
  input logic [7:0]  id_char_i,
  input logic [30:0] value_i,
  input logic        overflow_i,
  input logic        last_i
);

  // a stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(kind_i) && $stable(id_char_i) && $stable(value_i))
    else $error("stalled output beat changed");

  // only identifier characters can leave a token open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != kil_pkg::KIdent |-> last_i)
    else $error("non-identifier beat without last");

  // id_char and value only carried by their own kinds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (kind_i == kil_pkg::KIdent || id_char_i == 8'd0) &&
      (kind_i == kil_pkg::KInt || value_i == 31'd0))
    else $error("payload field set for wrong kind");

  // overflow flag only on identifiers and integers, kind in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      kind_i <= kil_pkg::KIllegal &&
      (!overflow_i || kind_i == kil_pkg::KIdent || kind_i == kil_pkg::KInt))
    else $error("bad kind or stray overflow");

endmodule

bind keyword_identifier_integer_lexer_unit kil_checker u_kil_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .kind_i     (out_o.kind),
  .id_char_i  (out_o.id_char),
  .value_i    (out_o.value),
  .overflow_i (out_o.overflow),
  .last_i     (out_o.last)
);

/* tb/keyword_identifier_integer_lexer_unit_tb.sv */
// testbench of the keyword/identifier/integer lexer: token prediction and beat-by-beat check
module keyword_identifier_integer_lexer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxWord = kil_pkg::MaxWordDef;

  // scanner state of the predictor
  typedef enum logic [2:0] {
    ScanIdle,
    ScanWord,
    ScanNumber,
    ScanColon,
    ScanSlash,
    ScanComment,
    ScanStar
  } scan_e;

  typedef struct {
    kil_pkg::kind_e kind;
    logic [7:0]     id_char;
    logic [30:0]    value;
    logic           overflow;
    logic           last;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kil_in_if  in_if ();
  kil_out_if out_if ();

  keyword_identifier_integer_lexer_unit #(
    .MaxWord(MaxWord)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // keyword spellings, in the order of their kind codes starting at KwBegin
  string keyword_text[5] = '{"begin", "end", "if", "then", "else"};
  string op_chars        = "+-*(),;=/:";
  string illegal_chars   = "#$%!?@[]";
  string comment_fill    = "ab*/ 9*x";

  // predictor state
  scan_e       lex_mode;
  logic [7:0]  word_buf [MaxWord];
  int unsigned word_len;
  logic [30:0] num_acc;
  bit          sat_seen;

  token_t pending_tokens[$];
  int     mismatches;
  int     chars_sent;

  // pacing knobs of the sender and the receiver
  bit idle_on;
  int gap_pct;
  int stall_pct;
  int hold_req;
  int hold_left;
  int stall_left;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c < 8'd32 || c == 8'h7f || c == " ";
  endfunction

  function automatic void add_token(kil_pkg::kind_e k, logic [7:0] c = '0,
                                    logic [30:0] v = '0, bit o = 1'b0, bit l = 1'b1);
    token_t t;
    t.kind     = k;
    t.id_char  = c;
    t.value    = v;
    t.overflow = o;
    t.last     = l;
    pending_tokens.push_back(t);
  endfunction

  function automatic bit word_spells(string kw);
    if (kw.len() != word_len) return 1'b0;
    for (int i = 0; i < kw.len(); i++)
      if (word_buf[i] != kw[i]) return 1'b0;
    return 1'b1;
  endfunction

  // a finished word: keyword token, or one beat per buffered character
  function automatic void flush_word();
    int kw;
    kw = -1;
    if (!sat_seen)
      for (int k = 0; k < 5; k++)
        if (kw < 0 && word_spells(keyword_text[k])) kw = k;
    if (kw >= 0) begin
      add_token(kil_pkg::kind_e'(int'(kil_pkg::KwBegin) + kw));
    end else begin
      for (int i = 0; i < word_len; i++)
        add_token(kil_pkg::KIdent, word_buf[i], '0, sat_seen, i + 1 == word_len);
    end
    word_len = 0;
    sat_seen = 1'b0;
  endfunction

  function automatic void flush_number();
    add_token(kil_pkg::KInt, '0, num_acc, sat_seen);
    num_acc  = '0;
    sat_seen = 1'b0;
  endfunction

  // a character seen from idle
  function automatic void open_token(logic [7:0] c);
    lex_mode = ScanIdle;
    if (is_blank(c)) return;
    if (is_letter(c)) begin
      word_buf[0] = c;
      word_len    = 1;
      sat_seen    = 1'b0;
      lex_mode    = ScanWord;
      return;
    end
    if (is_digit(c)) begin
      num_acc  = 31'(c - "0");
      sat_seen = 1'b0;
      lex_mode = ScanNumber;
      return;
    end
    case (c)
      ":": lex_mode = ScanColon;
      "/": lex_mode = ScanSlash;
      "+": add_token(kil_pkg::KPlus);
      "-": add_token(kil_pkg::KMinus);
      "*": add_token(kil_pkg::KStar);
      "(": add_token(kil_pkg::KLParen);
      ")": add_token(kil_pkg::KRParen);
      ",": add_token(kil_pkg::KComma);
      ";": add_token(kil_pkg::KSemi);
      "=": add_token(kil_pkg::KEqual);
      default: add_token(kil_pkg::KIllegal);
    endcase
  endfunction

  function automatic void scan_char(logic [7:0] c, bit eoi);
    longint unsigned nv;
    if (eoi) begin
      case (lex_mode)
        ScanWord:   flush_word();
        ScanNumber: flush_number();
        ScanColon:  add_token(kil_pkg::KColon);
        ScanSlash:  add_token(kil_pkg::KSlash);
        default: ;
      endcase
      lex_mode = ScanIdle;
      return;
    end
    case (lex_mode)
      ScanWord: begin
        if (is_letter(c) || is_digit(c)) begin
          if (word_len < MaxWord) begin
            word_buf[word_len] = c;
            word_len++;
          end else begin
            sat_seen = 1'b1;
          end
        end else begin
          flush_word();
          open_token(c);
        end
      end
      ScanNumber: begin
        if (is_digit(c)) begin
          nv = longint'(num_acc) * 10 + longint'(c - "0");
          // saturate rather than wrap
          if (nv > longint'(kil_pkg::ValueMax)) begin
            nv       = longint'(kil_pkg::ValueMax);
            sat_seen = 1'b1;
          end
          num_acc = 31'(nv);
        end else begin
          flush_number();
          open_token(c);
        end
      end
      ScanColon: begin
        if (c == "=") begin
          lex_mode = ScanIdle;
          add_token(kil_pkg::KAssign);
        end else begin
          add_token(kil_pkg::KColon);
          open_token(c);
        end
      end
      ScanSlash: begin
        if (c == "*") begin
          lex_mode = ScanComment;
        end else begin
          add_token(kil_pkg::KSlash);
          open_token(c);
        end
      end
      ScanComment: begin
        if (c == "*") lex_mode = ScanStar;
      end
      ScanStar: begin
        if (c == "/") lex_mode = ScanIdle;
        else if (c != "*") lex_mode = ScanComment;
      end
      default: open_token(c);
    endcase
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: kind %0d id_char %h value %0d ovf %b last %b",
                   out_if.kind, out_if.id_char, out_if.value, out_if.overflow, out_if.last);
      end else begin
        want = pending_tokens.pop_front();
        if (out_if.kind !== want.kind || out_if.id_char !== want.id_char ||
            out_if.value !== want.value || out_if.overflow !== want.overflow ||
            out_if.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"token mismatch at %0t: expected kind %0d id_char %h value %0d ",
                      "ovf %b last %b, got kind %0d id_char %h value %0d ovf %b last %b"},
                     $realtime, want.kind, want.id_char, want.value, want.overflow,
                     want.last, out_if.kind, out_if.id_char, out_if.value,
                     out_if.overflow, out_if.last);
        end
      end
    end
  end

  // ------------------------------------------------------------ token receiver

  // a requested hold wins over the random stall bursts
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------- char sender

  // valid stays high from one beat to the next unless a gap is drawn
  task automatic send_char(logic [7:0] c, bit eoi = 1'b0);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.ch           <= c;
    in_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    scan_char(c, eoi);
    if (eoi || !is_blank(c)) chars_sent++;
  endtask

  task automatic send_eoi();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // sender stops and waits for every predicted token
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range("a", "z"));
    return 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range("0", "9"));
  endfunction

  // one mostly well-formed lexeme, sometimes glued to the next one
  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      send_text(keyword_text[$urandom_range(0, 4)]);
    end else if (pick < 7) begin
      // mostly short words, now and then past the buffer depth
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(MaxWord - 1, MaxWord + 6)
                                      : $urandom_range(1, 8);
      send_char(rand_letter());
      repeat (n - 1) send_char($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
    end else if (pick < 10) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 6);
      repeat (n) send_char(rand_digit());
    end else if (pick < 13) begin
      send_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
    end else if (pick == 13) begin
      send_text(":=");
    end else if (pick == 14) begin
      send_text("/*");
      n = $urandom_range(0, 8);
      repeat (n) send_char(comment_fill[$urandom_range(0, comment_fill.len() - 1)]);
      if ($urandom_range(0, 1)) send_text("*/");
      else send_text("**/");
    end else if (pick == 15) begin
      if ($urandom_range(0, 1)) send_char(8'($urandom_range(128, 255)));
      else send_char(illegal_chars[$urandom_range(0, illegal_chars.len() - 1)]);
    end else if (pick == 16) begin
      send_char(8'($urandom_range(0, 255)));
    end else if (pick == 17) begin
      send_eoi();
    end else begin
      case ($urandom_range(0, 3))
        0: send_char(" ");
        1: send_char("\t");
        2: send_char(8'($urandom_range(0, 31)));
        default: send_char(8'h7f);
      endcase
    end
    if ($urandom_range(0, 9) < 6) send_char(" ");
  endtask

  // -------------------------------------------------------------------- tests

  // every keyword and operator, comment forms, flush of colon and slash
  task automatic test_keywords_and_operators();
    send_text("begin;end(if)then,else");
    send_text("a:=12+b9-c*3=4:/");
    send_eoi();
    send_text("/*x**/#");
    send_char(8'hff);
    send_char(8'h00);
    send_char(8'h7f);
    send_char(8'h80);
    send_char("\t");
    wait_drained();
  endtask

  // largest integer, saturation, truncated word, flush at end of input
  task automatic test_field_limits();
    send_text("2147483647 99999999999 ");
    send_text("BeginABCDEFGHIJKLMNOPq7 ");
    send_text("ab");
    send_eoi();
    send_text("12");
    send_eoi();
    send_text("/*ab");
    send_eoi();
    send_eoi();
    wait_drained();
  endtask

  // random lexemes with pacing that changes every few dozen tokens
  task automatic test_random_stream(int count);
    int stop_at;
    int tokens;
    stop_at = chars_sent + count;
    tokens  = 0;
    while (chars_sent < stop_at) begin
      if (tokens % 40 == 0) begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      send_random_token();
      tokens++;
    end
    wait_drained();
  endtask

  // receiver holds off while long words keep coming, so the input stalls
  task automatic test_output_backpressure();
    gap_pct  = 0;
    hold_req = 400;
    repeat (4) send_text("abcdefghijklmnopqrst ");
    send_text("x1;y2;z3;");
    wait_drained();
  endtask

  // scan state must survive a sender pause in the middle of a word and a number
  task automatic test_pause_mid_token();
    gap_pct   = 10;
    stall_pct = 10;
    send_text("+ab");
    wait_drained();
    send_text("cd 42");
    wait_drained();
    send_text("7:");
    wait_drained();
    send_text("=");
    wait_drained();
  endtask

  // back-to-back beats on both sides
  task automatic test_steady_stream(int count);
    int stop_at;
    idle_on = 1'b0;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) send_random_token();
    wait_drained();
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.ch           = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    lex_mode   = ScanIdle;
    word_len   = 0;
    num_acc    = '0;
    sat_seen   = 1'b0;
    mismatches = 0;
    chars_sent = 0;
    idle_on    = 1'b1;
    gap_pct    = 20;
    stall_pct  = 20;
    hold_req   = 0;
    hold_left  = 0;
    stall_left = 0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_keywords_and_operators();
    test_field_limits();
    test_random_stream(120);
    test_output_backpressure();
    test_pause_mid_token();
    test_steady_stream(80);

    // let any stray beat show up before the verdict
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
